[sv/swhc_pkg.sv]
// shared types and constants for the sliding window hit counter
package swhc_pkg;

  localparam int unsigned TS_W    = 32;
  localparam int unsigned WIN_W   = 16;
  localparam int unsigned COUNT_W = 11;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd300;

  localparam logic CMD_HIT   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic            cmd;
    logic [TS_W-1:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] hit_count;
    logic               lost_hits;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXPIRE
  } state_t;

  typedef struct packed {
    logic load;
    logic pop;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic expire;
  } dp_status_t;

endpackage

[sv/swhc_ram.sv]
// generic single write port ram with registered read
module swhc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/swhc_ctrl.sv]
// controller state machine: accept, expire loop, finish
module swhc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  swhc_pkg::dp_status_t status_i,
  output swhc_pkg::ctrl_cmd_t  cmd_o
);

  swhc_pkg::state_t state_r;
  swhc_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swhc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swhc_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = swhc_pkg::ST_EXPIRE;
        end
      end
      swhc_pkg::ST_EXPIRE: begin
        if (!status_i.expire) begin
          state_nxt = swhc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = swhc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy         = 1'b0;
    cmd_o.load   = 1'b0;
    cmd_o.pop    = 1'b0;
    cmd_o.finish = 1'b0;
    case (state_r)
      swhc_pkg::ST_IDLE: begin
        cmd_o.load = start;
      end
      swhc_pkg::ST_EXPIRE: begin
        busy         = 1'b1;
        cmd_o.pop    = status_i.expire;
        cmd_o.finish = !status_i.expire;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

[sv/swhc_dpath.sv]
// datapath: ring pointers, count, window register, expiry compare, result register
module swhc_dpath #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  swhc_pkg::in_item_t                 in_item,
  input  logic                               cfg_we,
  input  logic [swhc_pkg::WIN_W-1:0]         cfg_wdata,
  input  swhc_pkg::ctrl_cmd_t                cmd_i,
  output swhc_pkg::dp_status_t               status_o,
  output logic                               ram_we,
  output logic [$clog2(DEPTH)-1:0]           ram_waddr,
  output logic [swhc_pkg::TS_W-1:0]          ram_wdata,
  output logic [$clog2(DEPTH)-1:0]           ram_raddr,
  input  logic [swhc_pkg::TS_W-1:0]          ram_rdata,
  output swhc_pkg::out_item_t                out_item,
  output logic                               out_valid
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [IDX_W-1:0]          head_r, head_nxt;
  logic [IDX_W-1:0]          tail_r, tail_nxt;
  logic [CNT_W-1:0]          held_r, held_nxt;
  logic                      lost_r, lost_nxt;
  logic [swhc_pkg::WIN_W-1:0] win_r;
  swhc_pkg::in_item_t        item_r;
  logic                      out_valid_r, out_valid_nxt;
  swhc_pkg::out_item_t       out_item_r;
  logic [swhc_pkg::TS_W:0]   limit;
  logic                      full;
  logic                      push;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] pos);
    ring_next = (pos == LAST_IDX) ? '0 : pos + 1'b1;
  endfunction

  assign limit = {1'b0, ram_rdata} + {{(swhc_pkg::TS_W + 1 - swhc_pkg::WIN_W){1'b0}}, win_r};
  assign status_o.expire = (held_r != '0) && (limit <= {1'b0, item_r.timestamp});
  assign full = (held_r == FULL_CNT);
  assign push = cmd_i.finish && (item_r.cmd == swhc_pkg::CMD_HIT) && !full;

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    held_nxt      = held_r;
    lost_nxt      = lost_r;
    out_valid_nxt = 1'b0;
    if (cmd_i.pop) begin
      head_nxt = ring_next(head_r);
      held_nxt = held_r - 1'b1;
    end
    if (cmd_i.finish) begin
      if (item_r.cmd == swhc_pkg::CMD_QUERY) begin
        out_valid_nxt = 1'b1;
      end else if (full) begin
        lost_nxt = 1'b1;
      end else begin
        tail_nxt = ring_next(tail_r);
        held_nxt = held_r + 1'b1;
      end
    end
  end

  // read address follows the next head so the registered read shows that entry in the next cycle
  assign ram_raddr = head_nxt;
  assign ram_we    = push;
  assign ram_waddr = tail_r;
  assign ram_wdata = item_r.timestamp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      held_r      <= '0;
      lost_r      <= 1'b0;
      win_r       <= swhc_pkg::WINDOW_RESET;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      held_r      <= held_nxt;
      lost_r      <= lost_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        win_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      item_r <= in_item;
    end
    if (out_valid_nxt) begin
      out_item_r.hit_count <= swhc_pkg::COUNT_W'(held_r);
      out_item_r.lost_hits <= lost_r;
    end
  end

  assign out_item  = out_item_r;
  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= FULL_CNT)
    else $error("held count above ring depth");

  a_pop_finish_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd_i.pop && cmd_i.finish))
    else $error("pop and finish in the same cycle");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.pop |-> (held_r != '0))
    else $error("pop from an empty ring");

  a_out_after_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd_i.finish && item_r.cmd == swhc_pkg::CMD_QUERY))
    else $error("result strobe without a finished query");

  a_lost_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(lost_r) && $past(rst_n) |-> lost_r)
    else $error("lost flag cleared outside reset");
`endif

endmodule

[sv/sliding_window_hit_counter.sv]
// an item is loaded while idle, then each expired ring entry is popped and the item finishes; busy is high meanwhile
// the expiry loop reads one head entry per cycle from the ring ram read port
// a query result strobes out_valid for one cycle, the cycle after its item completes
// the receiver cannot stall; a hit produces no result
// synchronous reset clears pointers, count and lost flag and sets the window to 300
// ring contents are not cleared; only written entries are ever read
module sliding_window_hit_counter #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  swhc_pkg::in_item_t         in_item,
  input  logic                       cfg_we,
  input  logic [swhc_pkg::WIN_W-1:0] cfg_wdata,
  output swhc_pkg::out_item_t        out_item,
  output logic                       out_valid
);

  localparam int unsigned IDX_W = $clog2(DEPTH);

  swhc_pkg::ctrl_cmd_t  cmd;
  swhc_pkg::dp_status_t status;
  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  logic [swhc_pkg::TS_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]           ram_raddr;
  logic [swhc_pkg::TS_W-1:0]  ram_rdata;

  swhc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  swhc_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_i     (cmd),
    .status_o  (status),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_item  (out_item),
    .out_valid (out_valid)
  );

  swhc_ram #(
    .WIDTH (swhc_pkg::TS_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[tb/sliding_window_hit_counter_tb.sv]
// self-checking testbench for the sliding window hit counter
`timescale 1ns / 1ps

module sliding_window_hit_counter_tb;

  localparam int unsigned RING_DEPTH = 1024;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned NUM_ROWS = 27;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic                       cmd;
    logic [swhc_pkg::TS_W-1:0]  ts;
    logic [swhc_pkg::WIN_W-1:0] wdata;
    bit                         typed;
    int unsigned                count;
    logic                       lost;
  } stim_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  swhc_pkg::in_item_t         in_item;
  logic                       cfg_we;
  logic [swhc_pkg::WIN_W-1:0] cfg_wdata;
  swhc_pkg::out_item_t        out_item;
  logic                       out_valid;

  logic [swhc_pkg::TS_W-1:0]  stamp_store [RING_DEPTH];
  int unsigned                head_pos;
  int unsigned                tail_pos;
  int unsigned                held_num;
  logic                       lost_seen;
  logic [swhc_pkg::WIN_W-1:0] window_len;
  logic [swhc_pkg::TS_W-1:0]  cur_ts;

  swhc_pkg::out_item_t        count_answers [$];
  int unsigned                error_count;
  stim_row_t                  stim_rows [NUM_ROWS];

  sliding_window_hit_counter #(
    .DEPTH(RING_DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_item(out_item),
    .out_valid(out_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    if (error_count < 10) begin
      $display("%0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // expire old stamps, then store a hit (or mark it lost if the ring is full) or answer a query
  task automatic predict_request(input swhc_pkg::in_item_t req, output bit answers,
                                 output swhc_pkg::out_item_t ans);
    logic [swhc_pkg::TS_W:0] limit;
    answers = 1'b0;
    ans = '0;
    while (held_num != 0) begin
      limit = {1'b0, stamp_store[head_pos]} + (swhc_pkg::TS_W+1)'(window_len);
      if (limit > {1'b0, req.timestamp}) begin
        break;
      end
      head_pos = (head_pos == RING_DEPTH - 1) ? 0 : head_pos + 1;
      held_num--;
    end
    if (req.cmd == swhc_pkg::CMD_HIT) begin
      if (held_num >= RING_DEPTH) begin
        lost_seen = 1'b1;
      end else begin
        stamp_store[tail_pos] = req.timestamp;
        tail_pos = (tail_pos == RING_DEPTH - 1) ? 0 : tail_pos + 1;
        held_num++;
      end
    end else begin
      answers = 1'b1;
      ans.hit_count = swhc_pkg::COUNT_W'(held_num);
      ans.lost_hits = lost_seen;
    end
  endtask

  task automatic send_request(input logic cmd, input logic [swhc_pkg::TS_W-1:0] ts,
                              input bit typed, input swhc_pkg::out_item_t typed_ans);
    swhc_pkg::in_item_t  req;
    bit                  answers;
    swhc_pkg::out_item_t ans;
    req.cmd = cmd;
    req.timestamp = ts;
    @(negedge clk);
    start <= 1'b1;
    in_item <= req;
    do begin
      @(posedge clk);
    end while (busy);
    predict_request(req, answers, ans);
    if (answers) begin
      count_answers.push_back(typed ? typed_ans : ans);
    end
  endtask

  task automatic idle_gap(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // stop sending and wait until every answer is in and the block is quiet
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    do begin
      @(posedge clk);
    end while (count_answers.size() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [swhc_pkg::WIN_W-1:0] w);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we <= 1'b0;
    window_len = w;
  endtask

  task automatic random_burst(input int unsigned n, input int unsigned step_max,
                              input bit calm);
    int unsigned pick;
    logic        cmd;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        cur_ts = $urandom;
      end else if (pick < 10) begin
        cur_ts = cur_ts + 2 * window_len + $urandom_range(0, 1000);
      end else begin
        cur_ts = cur_ts + $urandom_range(0, step_max);
      end
      cmd = ($urandom_range(0, 99) < 65) ? swhc_pkg::CMD_HIT : swhc_pkg::CMD_QUERY;
      if (!calm && $urandom_range(0, 4) == 0) begin
        idle_gap($urandom_range(1, 6));
      end
      if (!calm && $urandom_range(0, 99) == 0) begin
        drain();
      end
      send_request(cmd, cur_ts, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    swhc_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (count_answers.size() == 0) begin
        flag_error($sformatf("unexpected answer count=%0d lost=%0d",
                             out_item.hit_count, out_item.lost_hits));
      end else begin
        want = count_answers.pop_front();
        if (out_item.hit_count !== want.hit_count ||
            out_item.lost_hits !== want.lost_hits) begin
          flag_error($sformatf(
            "answer mismatch: expected count=%0d lost=%0d, got count=%0d lost=%0d",
            want.hit_count, want.lost_hits, out_item.hit_count, out_item.lost_hits));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("** sliding_window_hit_counter: FAILED **");
    $finish;
  end

  initial begin
    swhc_pkg::out_item_t typed_ans;
    int unsigned         n_fill;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    error_count = 0;
    head_pos = 0;
    tail_pos = 0;
    held_num = 0;
    lost_seen = 1'b0;
    window_len = swhc_pkg::WINDOW_RESET;
    cur_ts = '0;

    stim_rows = '{
      '{ROW_REQ, swhc_pkg::CMD_QUERY, 32'd0,          16'd0,     1, 0, 1'b0},
      '{ROW_REQ, swhc_pkg::CMD_HIT,   32'd0,          16'd0,     0, 0, 1'b0},
      '{ROW_REQ, swhc_pkg::CMD_HIT,   32'd100,        16'd0,     0, 0, 1'b0},
      '{ROW_REQ, swhc_pkg::CMD_QUERY, 32'd299,        16'd0,     1, 2, 1'b0},
      '{ROW_REQ, swhc_pkg::CMD_QUERY, 32'd300,        16'd0,     1, 1, 1'b0},
      '{ROW_REQ, swhc_pkg::CMD_HIT,   32'd300,        16'd0,     0, 0, 1'b0},
      '{ROW_REQ, swhc_pkg::CMD_QUERY, 32'd399,        16'd0,     1, 2, 1'b0},
      '{ROW_REQ, swhc_pkg::CMD_QUERY, 32'd400,        16'd0,     1, 1, 1'b0},
      '{ROW_REQ, swhc_pkg::CMD_QUERY, 32'hFFFF_FFFF,  16'd0,     1, 0, 1'b0},
      '{ROW_REQ, swhc_pkg::CMD_HIT,   32'hFFFF_FFFF,  16'd0,     0, 0, 1'b0},
      '{ROW_REQ, swhc_pkg::CMD_HIT,   32'd5,          16'd0,     0, 0, 1'b0},
      '{ROW_REQ, swhc_pkg::CMD_QUERY, 32'd10,         16'd0,     1, 2, 1'b0},
      '{ROW_REQ, swhc_pkg::CMD_QUERY, 32'hFFFF_FFFF,  16'd0,     1, 2, 1'b0},
      '{ROW_CFG, swhc_pkg::CMD_HIT,   32'd0,          16'd0,     0, 0, 1'b0},
      '{ROW_REQ, swhc_pkg::CMD_QUERY, 32'd0,          16'd0,     0, 0, 1'b0},
      '{ROW_REQ, swhc_pkg::CMD_QUERY, 32'hFFFF_FFFF,  16'd0,     1, 0, 1'b0},
      '{ROW_REQ, swhc_pkg::CMD_HIT,   32'd50,         16'd0,     0, 0, 1'b0},
      '{ROW_REQ, swhc_pkg::CMD_QUERY, 32'd50,         16'd0,     1, 0, 1'b0},
      '{ROW_REQ, swhc_pkg::CMD_HIT,   32'd60,         16'd0,     0, 0, 1'b0},
      '{ROW_REQ, swhc_pkg::CMD_HIT,   32'd60,         16'd0,     0, 0, 1'b0},
      '{ROW_REQ, swhc_pkg::CMD_QUERY, 32'd59,         16'd0,     0, 0, 1'b0},
      '{ROW_CFG, swhc_pkg::CMD_HIT,   32'd0,          16'hFFFF,  0, 0, 1'b0},
      '{ROW_REQ, swhc_pkg::CMD_QUERY, 32'd65594,      16'd0,     0, 0, 1'b0},
      '{ROW_REQ, swhc_pkg::CMD_QUERY, 32'd65595,      16'd0,     0, 0, 1'b0},
      '{ROW_CFG, swhc_pkg::CMD_HIT,   32'd0,          16'd1,     0, 0, 1'b0},
      '{ROW_REQ, swhc_pkg::CMD_HIT,   32'd70000,      16'd0,     0, 0, 1'b0},
      '{ROW_REQ, swhc_pkg::CMD_QUERY, 32'd70000,      16'd0,     0, 0, 1'b0}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        write_window(stim_rows[i].wdata);
      end else begin
        typed_ans.hit_count = swhc_pkg::COUNT_W'(stim_rows[i].count);
        typed_ans.lost_hits = stim_rows[i].lost;
        send_request(stim_rows[i].cmd, stim_rows[i].ts, stim_rows[i].typed, typed_ans);
      end
    end

    // general traffic across several windows, extremes included
    write_window(16'd1);
    cur_ts = $urandom;
    random_burst(100, 2, 1'b0);
    write_window(16'hFFFF);
    cur_ts = 32'hFFFF_F000;
    random_burst(150, 3000, 1'b0);
    write_window(16'($urandom_range(1, 65535)));
    cur_ts = $urandom;
    random_burst(150, 64, 1'b0);
    write_window(16'($urandom_range(1, 20)));
    random_burst(100, 8, 1'b0);

    // fill the ring past its depth so hits are dropped
    write_window(16'hFFFF);
    cur_ts = $urandom_range(0, 32'h7FFF_FFFF);
    for (n_fill = 0; n_fill < 1100; n_fill++) begin
      if ($urandom_range(0, 4) == 0) begin
        idle_gap($urandom_range(1, 6));
      end
      cur_ts = cur_ts + $urandom_range(0, 1);
      send_request(($urandom_range(0, 99) < 97) ? swhc_pkg::CMD_HIT : swhc_pkg::CMD_QUERY,
                   cur_ts, 1'b0, '0);
    end
    send_request(swhc_pkg::CMD_QUERY, cur_ts, 1'b0, '0);
    cur_ts = cur_ts + 32'd70000;
    send_request(swhc_pkg::CMD_QUERY, cur_ts, 1'b0, '0);

    // closing stretch at full rate
    write_window(16'd300);
    random_burst(120, 100, 1'b1);

    drain();
    if (count_answers.size() != 0) begin
      flag_error($sformatf("%0d answers never arrived", count_answers.size()));
    end
    if (error_count == 0) begin
      $display("** sliding_window_hit_counter: PASSED **");
    end else begin
      $display("** sliding_window_hit_counter: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
sv/swhc_pkg.sv
sv/swhc_ram.sv
sv/swhc_ctrl.sv
sv/swhc_dpath.sv
sv/sliding_window_hit_counter.sv
tb/sliding_window_hit_counter_tb.sv
